@@ hdl/hamlim_pkg.sv @@
`default_nettype none

package hamlim_pkg;

    // default angle width, two's complement, fraction in the low bits
    localparam int ANGLE_BITS_DEF = 16;
    // gain is unsigned Q0.16
    localparam int GAIN_BITS = 16;

    localparam int CFG_INDEX_BITS = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MOTION_ENABLE   = 3'd0,
        CFG_YAW_LOWER       = 3'd1,
        CFG_YAW_UPPER       = 3'd2,
        CFG_PITCH_LOWER     = 3'd3,
        CFG_PITCH_UPPER     = 3'd4,
        CFG_STEP_GAIN       = 3'd5,
        CFG_MAX_STEP        = 3'd6,
        CFG_MAX_STEP_CHANGE = 3'd7
    } cfg_index_t;

    // register values after reset
    localparam int MOTION_ENABLE_RST   = 1;
    localparam int YAW_LOWER_RST       = -8602;
    localparam int YAW_UPPER_RST       = 8602;
    localparam int PITCH_LOWER_RST     = -2048;
    localparam int PITCH_UPPER_RST     = 2048;
    localparam int STEP_GAIN_RST       = 5243;
    localparam int MAX_STEP_RST        = 200;
    localparam int MAX_STEP_CHANGE_RST = 8;

    // per-axis control from the top level
    typedef struct packed {
        logic update;   // commit the new angle into the axis state
        logic enable;   // motion allowed: give the new angle, else the current one
    } axis_ctl_t;

endpackage

`default_nettype wire

@@ hdl/hamlim_axis.sv @@
`default_nettype none

module hamlim_axis
    import hamlim_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire axis_ctl_t                    ctl,
    input  wire logic signed [ANGLE_BITS-1:0] target,
    input  wire logic signed [ANGLE_BITS-1:0] lower,
    input  wire logic signed [ANGLE_BITS-1:0] upper,
    input  wire logic        [GAIN_BITS-1:0]  gain,
    input  wire logic        [ANGLE_BITS-2:0] max_step,
    input  wire logic        [ANGLE_BITS-2:0] max_step_change,
    output logic signed      [ANGLE_BITS-1:0] angle
);

    localparam int W1 = ANGLE_BITS + 1;
    localparam int W2 = ANGLE_BITS + 2;
    localparam int W3 = ANGLE_BITS + 3;
    localparam int WP = ANGLE_BITS + GAIN_BITS + 1;

    logic signed [ANGLE_BITS-1:0] now_reg;
    logic signed [ANGLE_BITS-1:0] before_reg;

    logic signed [ANGLE_BITS-1:0] t_clamp;
    logic signed [W1-1:0]         err;
    logic signed [GAIN_BITS:0]    gain_s;
    logic signed [WP-1:0]         prod;
    logic signed [W1-1:0]         want_raw;
    logic signed [W1-1:0]         ms;
    logic signed [W1-1:0]         want;
    logic signed [W1-1:0]         vel;
    logic signed [W2-1:0]         diff;
    logic signed [W2-1:0]         mc;
    logic signed [W2-1:0]         change;
    logic signed [W3-1:0]         sum;
    logic signed [W3-1:0]         lo_x;
    logic signed [W3-1:0]         hi_x;
    logic signed [W3-1:0]         sum_clamp;
    logic signed [ANGLE_BITS-1:0] next_angle;

    always_comb
    begin
        // upper first, then lower, so an inverted window settles on lower
        t_clamp = target;
        if (t_clamp > upper)
        begin
            t_clamp = upper;
        end
        if (t_clamp < lower)
        begin
            t_clamp = lower;
        end

        err      = W1'(t_clamp) - W1'(now_reg);
        gain_s   = signed'({1'b0, gain});
        prod     = WP'(err) * WP'(gain_s);
        // arithmetic shift: rounds toward minus infinity
        want_raw = signed'(prod[WP-1:GAIN_BITS]);

        ms   = signed'({2'b00, max_step});
        want = want_raw;
        if (want > ms)
        begin
            want = ms;
        end
        if (want < -ms)
        begin
            want = -ms;
        end

        vel  = W1'(now_reg) - W1'(before_reg);
        diff = W2'(want) - W2'(vel);
        mc   = signed'({3'b000, max_step_change});
        change = diff;
        if (change > mc)
        begin
            change = mc;
        end
        if (change < -mc)
        begin
            change = -mc;
        end

        sum  = W3'(now_reg) + W3'(vel) + W3'(change);
        lo_x = W3'(lower);
        hi_x = W3'(upper);
        sum_clamp = sum;
        if (sum_clamp > hi_x)
        begin
            sum_clamp = hi_x;
        end
        if (sum_clamp < lo_x)
        begin
            sum_clamp = lo_x;
        end
        next_angle = signed'(sum_clamp[ANGLE_BITS-1:0]);

        angle = ctl.enable ? next_angle : now_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg    <= '0;
            before_reg <= '0;
        end
        else if (ctl.update)
        begin
            before_reg <= now_reg;
            now_reg    <= next_angle;
        end
    end

endmodule

`default_nettype wire

@@ hdl/head_angle_motion_limiter.sv @@
`default_nettype none

// Yaw/pitch setpoint follower with velocity and acceleration limits. Each request on the
// s_ side carries a yaw and pitch target; one result per request comes out on the m_ side
// via the input register and then the result register; a new request is taken every cycle
// while the output is drained, as the per-axis update (target clamp, gain multiply, step and
// step-change clamps, window clamp) is combinational. Configuration is to be written
// through cfg_we/cfg_index/cfg_data only while no request is in flight; the block does
// not enforce it; motion_enable low returns the current angles and the state holds.

module head_angle_motion_limiter
    import hamlim_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    localparam int DATA_W = ((2 * ANGLE_BITS + 7) / 8) * 8,
    localparam int CFG_W  = (ANGLE_BITS > GAIN_BITS) ? ANGLE_BITS : GAIN_BITS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // target_yaw, target_pitch, zero fill
    input  wire logic [DATA_W-1:0]         s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // head_yaw, head_pitch, zero fill
    output logic [DATA_W-1:0]              m_tdata,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data
);

    logic                         motion_enable_reg;
    logic signed [ANGLE_BITS-1:0] yaw_lower_reg;
    logic signed [ANGLE_BITS-1:0] yaw_upper_reg;
    logic signed [ANGLE_BITS-1:0] pitch_lower_reg;
    logic signed [ANGLE_BITS-1:0] pitch_upper_reg;
    logic        [GAIN_BITS-1:0]  step_gain_reg;
    logic        [ANGLE_BITS-2:0] max_step_reg;
    logic        [ANGLE_BITS-2:0] max_step_change_reg;

    logic                         in_valid_reg;
    logic                         in_valid_next;
    logic signed [ANGLE_BITS-1:0] in_yaw_reg;
    logic signed [ANGLE_BITS-1:0] in_pitch_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic        [DATA_W-1:0]     out_data_reg;
    logic        [DATA_W-1:0]     out_word;

    logic                         advance;
    logic                         in_accept;
    logic                         in_move;
    axis_ctl_t                    ctl;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    logic signed [ANGLE_BITS-1:0] pitch_angle;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motion_enable_reg   <= 1'(MOTION_ENABLE_RST);
            yaw_lower_reg       <= ANGLE_BITS'(YAW_LOWER_RST);
            yaw_upper_reg       <= ANGLE_BITS'(YAW_UPPER_RST);
            pitch_lower_reg     <= ANGLE_BITS'(PITCH_LOWER_RST);
            pitch_upper_reg     <= ANGLE_BITS'(PITCH_UPPER_RST);
            step_gain_reg       <= GAIN_BITS'(STEP_GAIN_RST);
            max_step_reg        <= (ANGLE_BITS-1)'(MAX_STEP_RST);
            max_step_change_reg <= (ANGLE_BITS-1)'(MAX_STEP_CHANGE_RST);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MOTION_ENABLE:   motion_enable_reg   <= cfg_data[0];
                CFG_YAW_LOWER:       yaw_lower_reg       <= signed'(cfg_data[ANGLE_BITS-1:0]);
                CFG_YAW_UPPER:       yaw_upper_reg       <= signed'(cfg_data[ANGLE_BITS-1:0]);
                CFG_PITCH_LOWER:     pitch_lower_reg     <= signed'(cfg_data[ANGLE_BITS-1:0]);
                CFG_PITCH_UPPER:     pitch_upper_reg     <= signed'(cfg_data[ANGLE_BITS-1:0]);
                CFG_STEP_GAIN:       step_gain_reg       <= cfg_data[GAIN_BITS-1:0];
                CFG_MAX_STEP:        max_step_reg        <= cfg_data[ANGLE_BITS-2:0];
                CFG_MAX_STEP_CHANGE: max_step_change_reg <= cfg_data[ANGLE_BITS-2:0];
                default:             ;
            endcase
        end
    end

    // input stage moves on whenever the result register is free or being taken
    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;
    assign in_move   = in_valid_reg && advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_yaw_reg   <= signed'(s_tdata[ANGLE_BITS-1:0]);
            in_pitch_reg <= signed'(s_tdata[2*ANGLE_BITS-1:ANGLE_BITS]);
        end
        if (in_move)
        begin
            out_data_reg <= out_word;
        end
    end

    assign ctl.update = in_move && motion_enable_reg;
    assign ctl.enable = motion_enable_reg;

    hamlim_axis #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_yaw (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .target          (in_yaw_reg),
        .lower           (yaw_lower_reg),
        .upper           (yaw_upper_reg),
        .gain            (step_gain_reg),
        .max_step        (max_step_reg),
        .max_step_change (max_step_change_reg),
        .angle           (yaw_angle)
    );

    hamlim_axis #(
        .ANGLE_BITS(ANGLE_BITS)
    ) u_pitch (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .target          (in_pitch_reg),
        .lower           (pitch_lower_reg),
        .upper           (pitch_upper_reg),
        .gain            (step_gain_reg),
        .max_step        (max_step_reg),
        .max_step_change (max_step_change_reg),
        .angle           (pitch_angle)
    );

    always_comb
    begin
        out_word = '0;
        out_word[ANGLE_BITS-1:0]            = yaw_angle;
        out_word[2*ANGLE_BITS-1:ANGLE_BITS] = pitch_angle;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ hdl/hamlim_checker.sv @@
`default_nettype none

module hamlim_checker #(
    parameter int DATA_W = 32
)
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [DATA_W-1:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // no result may be pending once reset has been seen
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("result valid during reset");

    // an empty output register means the block can take a request
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("request refused with empty output");

    // one request taken behind a stalled result fills the block
    a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        $past(s_tvalid && s_tready && m_tvalid && !m_tready) && m_tvalid && !m_tready
        |-> !s_tready)
        else $error("request taken with both stages full");

endmodule

bind head_angle_motion_limiter hamlim_checker #(
    .DATA_W(DATA_W)
) u_hamlim_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
